@@ design/mmp_pkg.sv @@
// Shared types, constants and helpers for the MIDI message parser.
// No dependencies; imported by every other file of the block.
package mmp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned DATA_W   = 7;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned BEND_W   = 15;
    localparam int unsigned PHASE_W  = 4;
    localparam int unsigned OUT_W    = KIND_W + DATA_W + BYTE_W + BEND_W;

    // parser phases; codes above PH_PB2 behave as idle
    localparam logic [PHASE_W-1:0] PH_IDLE = 4'd0;
    localparam logic [PHASE_W-1:0] PH_ON1  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ON2  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_OFF1 = 4'd3;
    localparam logic [PHASE_W-1:0] PH_OFF2 = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CC1  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_CC2  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_PB1  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_PB2  = 4'd8;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_ON  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CC  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_PB  = 2'd3;

    // status byte upper nibbles
    localparam logic [3:0] ST_NOTE_OFF = 4'h8;
    localparam logic [3:0] ST_NOTE_ON  = 4'h9;
    localparam logic [3:0] ST_CTRL     = 4'hB;
    localparam logic [3:0] ST_BEND     = 4'hE;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] first_data;
        logic [BYTE_W-1:0] second_data;
        logic [BEND_W-1:0] bend_value;
    } t_event;

    // phase entered after a status byte; idle for unhandled status
    function automatic logic [PHASE_W-1:0] phase_after_status(input logic [BYTE_W-1:0] b);
        logic [PHASE_W-1:0] ph;
        unique case (b[7:4])
            ST_NOTE_ON:  ph = PH_ON1;
            ST_NOTE_OFF: ph = PH_OFF1;
            ST_CTRL:     ph = PH_CC1;
            ST_BEND:     ph = PH_PB1;
            default:     ph = PH_IDLE;
        endcase
        return ph;
    endfunction

endpackage

@@ design/mmp_parse.sv @@
// Parser state (phase, held first data byte) and per-byte event decode.
// Depends on mmp_pkg.
module mmp_parse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [mmp_pkg::BYTE_W-1:0]  i_byte,
    output mmp_pkg::t_event             o_event
);
    import mmp_pkg::*;

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [DATA_W-1:0]  r_held, n_held;
    t_event             evt;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        evt     = '0;
        unique case (r_phase) inside
            PH_ON1, PH_OFF1, PH_CC1, PH_PB1: begin
                if (i_byte[7]) begin
                    // status where data expected: restart on this byte
                    n_phase = phase_after_status(i_byte);
                end else begin
                    n_held  = i_byte[DATA_W-1:0];
                    n_phase = r_phase + PHASE_W'(1);
                end
            end
            PH_ON2, PH_OFF2, PH_CC2, PH_PB2: begin
                // running status: back to first data of same kind
                n_phase          = r_phase - PHASE_W'(1);
                evt.valid        = 1'b1;
                evt.first_data   = r_held;
                evt.second_data  = i_byte;
                unique case (r_phase)
                    PH_ON2:  evt.kind = (i_byte == '0) ? KIND_OFF : KIND_ON;
                    PH_OFF2: evt.kind = KIND_OFF;
                    PH_CC2:  evt.kind = KIND_CC;
                    default: begin
                        evt.kind       = KIND_PB;
                        evt.bend_value = {i_byte, r_held};
                    end
                endcase
            end
            default: begin
                n_phase = i_byte[7] ? phase_after_status(i_byte) : PH_IDLE;
            end
        endcase
        evt.valid = evt.valid & i_advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    assign o_event = evt;

endmodule

@@ design/mmp_out_reg.sv @@
// Result register with stream handshake toward the downstream side.
// Depends on mmp_pkg.
module mmp_out_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mmp_pkg::t_event             i_event,
    output logic                        o_free,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mmp_pkg::OUT_W-1:0]   o_data
);
    import mmp_pkg::*;

    logic              r_valid;
    logic [OUT_W-1:0]  r_data;

    // register can load when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_event.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_event.valid) begin
            r_data <= {i_event.bend_value, i_event.second_data,
                       i_event.first_data, i_event.kind};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ design/midi_message_parser_core.sv @@
// Top level of the MIDI message parser: byte stream in, event stream out.
// Depends on mmp_pkg, mmp_parse, mmp_out_reg.
//
// Takes one received MIDI byte per word and emits one event word after the
// second data byte of each note-on, note-off, control-change or pitch-bend
// message (channel ignored, running status kept, note-on with velocity zero
// reported as note-off). Other status bytes and stray data bytes produce
// nothing. A status byte arriving where a first data byte is expected
// restarts parsing on that byte; where a second data byte is expected it is
// taken as the data byte. One byte is accepted every clock; the event shows
// on the output the cycle after its last byte is accepted. The single result
// register sets the rate: s_axis_tready drops only while that register holds
// an event the downstream side has not taken.
module midi_message_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // event stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [1:0] event_kind, [8:2] first_data,
                                        // [16:9] second_data, [31:17] bend_value
);
    import mmp_pkg::*;

    t_event evt;
    logic   out_free;
    logic   accept;

    // byte taken whenever the result register can absorb its outcome
    assign s_axis_tready = out_free;
    assign accept        = s_axis_tvalid && out_free;

    mmp_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_byte    (s_axis_tdata),
        .o_event   (evt)
    );

    mmp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_event  (evt),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (m_axis_tdata)
    );

endmodule

@@ design/mmp_checker.sv @@
// Port-level checks for midi_message_parser_core, bound to the top level.
// Depends on mmp_pkg.
module mmp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata
);
    import mmp_pkg::*;

    // stalled event stays presented
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("event dropped while stalled");

    // a fresh event always follows an accepted byte
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready)
        |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("event without input byte");

    // bend field: combination for pitch bend, zero otherwise
    a_bend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        (m_axis_tdata[1:0] == KIND_PB) ?
            (m_axis_tdata[31:17] == {m_axis_tdata[16:9], m_axis_tdata[8:2]}) :
            (m_axis_tdata[31:17] == '0))
        else $error("bad bend value");

    // zero-velocity note-on is reported as note-off
    a_vel0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] == KIND_ON) |-> m_axis_tdata[16:9] != 8'd0)
        else $error("note-on with zero velocity");

endmodule

bind midi_message_parser_core mmp_checker u_mmp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
